FILE: rtl/core/opt_pkg.sv
// Shared types and constants for the ordered point table.
// Used by opt_cell, opt_count and ordered_point_table; no dependencies.
`default_nettype none

package opt_pkg;

  localparam int DEPTH    = 16;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int OP_W     = 3;
  localparam int COORD_W  = 16;
  localparam int RAD_W    = 16;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 5;
  localparam int PROD_W   = 2 * COORD_W;
  localparam int SQ_W     = 2 * COORD_W - 1;   // x*x of a signed 16-bit value
  localparam int RR_W     = 2 * RAD_W;

  typedef enum logic [OP_W-1:0] {
    OP_ADD       = 3'd0,
    OP_DEL_FRONT = 3'd1,
    OP_DEL_MATCH = 3'd2,
    OP_RADIUS    = 3'd3,
    OP_CONTAINS  = 3'd4,
    OP_LENGTH    = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROD,
    S_CMP,
    S_SUM,
    S_TOTAL,
    S_RESP
  } state_e;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic                      add_en;
    logic                      del_front_en;
    logic                      del_match_en;
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qy;
    logic [RR_W-1:0]           rr;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/opt_cell.sv
// One entry of the point chain: holds a point, squares it, compares it to
// the query and shifts toward either neighbor. Depends on opt_pkg.
`default_nettype none

module opt_cell (
  input  logic                              clk,
  input  opt_pkg::cell_ctl_t                ctl,
  input  logic                              active,
  input  logic signed [opt_pkg::COORD_W-1:0] left_x,
  input  logic signed [opt_pkg::COORD_W-1:0] left_y,
  input  logic signed [opt_pkg::COORD_W-1:0] right_x,
  input  logic signed [opt_pkg::COORD_W-1:0] right_y,
  input  logic                              hit_in,
  output logic signed [opt_pkg::COORD_W-1:0] x,
  output logic signed [opt_pkg::COORD_W-1:0] y,
  output logic                              hit_out,
  output logic                              in_rad
);

  logic signed [opt_pkg::PROD_W-1:0]    prod_x;
  logic signed [opt_pkg::PROD_W-1:0]    prod_y;
  logic [opt_pkg::SQ_W-1:0]             sq_x;
  logic [opt_pkg::SQ_W-1:0]             sq_y;
  logic [opt_pkg::RR_W-1:0]             dist2;
  logic                                 match;

  assign prod_x  = opt_pkg::PROD_W'(x) * opt_pkg::PROD_W'(x);
  assign prod_y  = opt_pkg::PROD_W'(y) * opt_pkg::PROD_W'(y);
  assign dist2   = opt_pkg::RR_W'(sq_x) + opt_pkg::RR_W'(sq_y);
  // first matching cell and everything behind it close the gap
  assign hit_out = hit_in | match;

  always_ff @(posedge clk) begin
    sq_x   <= prod_x[opt_pkg::SQ_W-1:0];
    sq_y   <= prod_y[opt_pkg::SQ_W-1:0];
    match  <= active && (x == ctl.qx) && (y == ctl.qy);
    in_rad <= active && (dist2 <= ctl.rr);
    if (ctl.add_en) begin
      x <= left_x;
      y <= left_y;
    end else if (ctl.del_front_en || (ctl.del_match_en && hit_out)) begin
      x <= right_x;
      y <= right_y;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/opt_count.sv
// Two-stage registered population count of the in-radius flags.
// Depends on opt_pkg.
`default_nettype none

module opt_count (
  input  logic                       clk,
  input  logic [opt_pkg::DEPTH-1:0]  flags,
  output logic [opt_pkg::CNT_W-1:0]  count
);

  localparam int NGROUP = (opt_pkg::DEPTH + 3) / 4;

  logic [2:0]                grp [NGROUP];
  logic [2:0]                grp_next [NGROUP];
  logic [opt_pkg::CNT_W-1:0] total;

  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_next[g] = 3'd0;
      for (int k = 0; k < 4; k++) begin
        if (g * 4 + k < opt_pkg::DEPTH) begin
          grp_next[g] = grp_next[g] + 3'(flags[g*4+k]);
        end
      end
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < NGROUP; g++) begin
      total = total + opt_pkg::CNT_W'(grp[g]);
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGROUP; g++) begin
      grp[g] <= grp_next[g];
    end
    count <= total;
  end

endmodule

`default_nettype wire

FILE: rtl/core/ordered_point_table.sv
// Ordered point table: a list of up to 16 signed 2-D points, newest first.
//
// Input channel s_*: one item carries an op (add front, remove front,
// remove match, radius count, contains, length), a point and a radius.
// Output channel m_*: one result item per input item, in order.
//
// Each item runs through a fixed sequence: square and compare in every cell,
// radius compare and list update, then a two-stage count, then the result
// register. The block accepts no new item until the result of the last one
// has been loaded into the result register, so items never overlap in the
// cell chain and count stages.
//
// The result sits in an output register; while the receiver stalls, the
// next item is still accepted and processed, and it waits in the final step
// until the register frees. Reset empties the list and drops any item in
// flight; stored point values are not cleared.
// Depends on opt_pkg, opt_cell and opt_count.
`default_nettype none

module ordered_point_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // op[2:0], coord_x[18:3], coord_y[34:19], radius[50:35]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // status[1:0], match_count[6:2], found[7], length[12:8]
);

  localparam int CW = opt_pkg::COORD_W;

  opt_pkg::state_e             state;
  opt_pkg::state_e             state_next;
  logic                        load_out;

  logic [opt_pkg::OP_W-1:0]    op;
  logic signed [CW-1:0]        qx;
  logic signed [CW-1:0]        qy;
  logic [opt_pkg::RAD_W-1:0]   radius;
  logic [opt_pkg::RR_W-1:0]    rr;
  logic [opt_pkg::CNT_W-1:0]   occupancy;
  logic [opt_pkg::CNT_W-1:0]   occupancy_next;
  logic [opt_pkg::STATUS_W-1:0] status_q;
  logic [opt_pkg::STATUS_W-1:0] status_next;
  logic                        found_q;

  logic [opt_pkg::STATUS_W-1:0] out_status;
  logic [opt_pkg::LEN_W-1:0]    out_count;
  logic                         out_found;
  logic [opt_pkg::LEN_W-1:0]    out_length;

  opt_pkg::cell_ctl_t          ctl;
  logic signed [CW-1:0]        cx  [opt_pkg::DEPTH];
  logic signed [CW-1:0]        cy  [opt_pkg::DEPTH];
  logic [opt_pkg::DEPTH:0]     hit;
  logic [opt_pkg::DEPTH-1:0]   in_rad;
  logic [opt_pkg::DEPTH-1:0]   active;
  logic [opt_pkg::CNT_W-1:0]   count;
  logic                        full;
  logic                        empty;

  assign s_tready = (state == opt_pkg::S_IDLE);
  assign m_tdata  = {3'b000, out_length, out_found, out_count, out_status};

  assign full  = (occupancy >= opt_pkg::CNT_W'(opt_pkg::DEPTH));
  assign empty = (occupancy == '0);

  assign ctl.add_en       = (state == opt_pkg::S_CMP) && (op == opt_pkg::OP_ADD) && !full;
  assign ctl.del_front_en = (state == opt_pkg::S_CMP) && (op == opt_pkg::OP_DEL_FRONT)
                            && !empty;
  assign ctl.del_match_en = (state == opt_pkg::S_CMP) && (op == opt_pkg::OP_DEL_MATCH);
  assign ctl.qx           = qx;
  assign ctl.qy           = qy;
  assign ctl.rr           = rr;

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < opt_pkg::DEPTH; i++) begin : g_cell
    logic signed [CW-1:0] lx;
    logic signed [CW-1:0] ly;
    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] ry;

    assign active[i] = (opt_pkg::CNT_W'(i) < occupancy);

    if (i == 0) begin : g_head
      assign lx = qx;
      assign ly = qy;
    end else begin : g_body
      assign lx = cx[i-1];
      assign ly = cy[i-1];
    end

    if (i == opt_pkg::DEPTH - 1) begin : g_tail
      assign rx = cx[i];
      assign ry = cy[i];
    end else begin : g_mid
      assign rx = cx[i+1];
      assign ry = cy[i+1];
    end

    opt_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .active  (active[i]),
      .left_x  (lx),
      .left_y  (ly),
      .right_x (rx),
      .right_y (ry),
      .hit_in  (hit[i]),
      .x       (cx[i]),
      .y       (cy[i]),
      .hit_out (hit[i+1]),
      .in_rad  (in_rad[i])
    );
  end

  opt_count u_count (
    .clk   (clk),
    .flags (in_rad),
    .count (count)
  );

  // status and occupancy of the update step
  always_comb begin
    occupancy_next = occupancy;
    status_next    = opt_pkg::ST_OK;
    case (op)
      opt_pkg::OP_ADD: begin
        if (full) begin
          status_next = opt_pkg::ST_FULL;
        end else begin
          occupancy_next = occupancy + 1'b1;
        end
      end
      opt_pkg::OP_DEL_FRONT: begin
        if (empty) begin
          status_next = opt_pkg::ST_MISS;
        end else begin
          occupancy_next = occupancy - 1'b1;
        end
      end
      opt_pkg::OP_DEL_MATCH: begin
        if (hit[opt_pkg::DEPTH]) begin
          occupancy_next = occupancy - 1'b1;
        end else begin
          status_next = opt_pkg::ST_MISS;
        end
      end
      opt_pkg::OP_CONTAINS: begin
        if (!hit[opt_pkg::DEPTH]) begin
          status_next = opt_pkg::ST_MISS;
        end
      end
      default: begin
        status_next = opt_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    case (state)
      opt_pkg::S_IDLE:  if (s_tvalid) state_next = opt_pkg::S_PROD;
      opt_pkg::S_PROD:  state_next = opt_pkg::S_CMP;
      opt_pkg::S_CMP:   state_next = opt_pkg::S_SUM;
      opt_pkg::S_SUM:   state_next = opt_pkg::S_TOTAL;
      opt_pkg::S_TOTAL: state_next = opt_pkg::S_RESP;
      opt_pkg::S_RESP: begin
        // hold until the output register is free
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = opt_pkg::S_IDLE;
        end
      end
      default: state_next = opt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= opt_pkg::S_IDLE;
      occupancy <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == opt_pkg::S_CMP) begin
        occupancy <= occupancy_next;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op     <= s_tdata[2:0];
      qx     <= s_tdata[18:3];
      qy     <= s_tdata[34:19];
      radius <= s_tdata[50:35];
    end
    if (state == opt_pkg::S_PROD) begin
      rr <= opt_pkg::RR_W'(radius) * opt_pkg::RR_W'(radius);
    end
    if (state == opt_pkg::S_CMP) begin
      status_q <= status_next;
      found_q  <= (op == opt_pkg::OP_CONTAINS) && hit[opt_pkg::DEPTH];
    end
    if (load_out) begin
      out_found  <= found_q;
      out_length <= opt_pkg::LEN_W'(occupancy);
      if (op == opt_pkg::OP_RADIUS) begin
        out_count  <= opt_pkg::LEN_W'(count);
        out_status <= (count == '0) ? opt_pkg::ST_MISS : opt_pkg::ST_OK;
      end else begin
        out_count  <= '0;
        out_status <= status_q;
      end
    end
  end

endmodule

`default_nettype wire
